@@ sv/hicu_pkg.sv @@
// hicu_pkg: widths, item types and shared-unit request types for the
// h-index core update block. No dependencies.
package hicu_pkg;

    localparam int TAG_W      = 16;
    localparam int CORE_W     = 10;
    localparam int BIN_W      = 10;
    localparam int MAX_DEGREE = 1023;
    localparam int DEPTH      = MAX_DEGREE + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CMP_W      = (ADDR_W > CORE_W) ? ADDR_W : CORE_W;
    localparam int SUM_W      = ((ADDR_W > BIN_W) ? ADDR_W : BIN_W) + 1;

    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic [TAG_W-1:0]  vertex_tag;
        logic [CORE_W-1:0] neighbour_core;
        logic [CORE_W-1:0] vertex_degree;
        logic [CORE_W-1:0] present_core;
        logic              counts;
        logic              final_item;
    } item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  result_tag;
        logic [CORE_W-1:0] updated_core;
        logic              lowered;
    } result_t;

    typedef enum logic {
        OP_INC,
        OP_ACC
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        sum_t             acc;
        logic [BIN_W-1:0] bin;
        addr_t            idx;
    } alu_req_t;

    typedef struct packed {
        sum_t value;
        logic reached;
    } alu_res_t;

endpackage

@@ sv/hicu_alu.sv @@
// hicu_alu: shared adder/comparator, saturating bin increment or suffix-sum
// accumulate with compare against the scan index. Uses hicu_pkg.
module hicu_alu (
    input  hicu_pkg::alu_req_t req,
    output hicu_pkg::alu_res_t res
);
    import hicu_pkg::*;

    sum_t addend;
    sum_t total;

    always_comb
    begin
        unique case (req.op)
            OP_INC:
            begin
                addend = (req.bin == BIN_MAX) ? '0 : sum_t'(1);
                total  = SUM_W'(req.bin) + addend;
            end
            OP_ACC:
            begin
                addend = SUM_W'(req.bin);
                total  = req.acc + addend;
            end
            default:
            begin
                addend = '0;
                total  = '0;
            end
        endcase
        res.value   = total;
        res.reached = (total >= SUM_W'(req.idx));
    end

endmodule

@@ sv/hicu_bin_ram.sv @@
// hicu_bin_ram: histogram bin store, one write and one registered read port.
// Uses hicu_pkg. Contents undefined until cleared by the sequencer.
module hicu_bin_ram (
    input  logic                    clk,
    input  logic                    we,
    input  hicu_pkg::addr_t         waddr,
    input  logic [hicu_pkg::BIN_W-1:0] wdata,
    input  hicu_pkg::addr_t         raddr,
    output logic [hicu_pkg::BIN_W-1:0] rdata
);
    import hicu_pkg::*;

    logic [BIN_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/h_index_core_update.sv @@
// h_index_core_update: per-vertex neighbour histogram and h-index scan.
// Uses hicu_pkg, hicu_alu, hicu_bin_ram.
// Non-final item: taken in ST_IDLE, then an ST_INC read-modify-write if it counts.
// Final item: ST_INC if counted, then ST_SCAN_RD and ST_SCAN down from the degree
// through the shared adder (none at degree 0), ST_EMIT, then a clear sweep over the
// touched bins, 1 bin/cycle. Reset: stall held while DEPTH (1024) bins clear.
module h_index_core_update (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hicu_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output hicu_pkg::result_t result
);
    import hicu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_SCAN_RD,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    state_t            state_reg, state_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    addr_t             deg_reg, deg_next;
    logic [CORE_W-1:0] present_reg, present_next;
    logic              final_reg, final_next;
    addr_t             pos_reg, pos_next;
    addr_t             idx_reg, idx_next;
    sum_t              sum_reg, sum_next;
    addr_t             h_reg, h_next;
    logic              touched_reg, touched_next;
    addr_t             hi_reg, hi_next;
    addr_t             lo_reg, lo_next;
    addr_t             clr_reg, clr_next;
    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic              accept;
    addr_t             deg_in;
    addr_t             pos_in;
    logic [CMP_W-1:0]  deg_cmp;
    logic [CMP_W-1:0]  ncore_cmp;
    logic [CMP_W-1:0]  h_cmp;
    logic [CMP_W-1:0]  pres_cmp;

    logic              ram_we;
    addr_t             ram_waddr;
    logic [BIN_W-1:0]  ram_wdata;
    addr_t             ram_raddr;
    logic [BIN_W-1:0]  ram_rdata;

    alu_req_t          alu_req;
    alu_res_t          alu_res;

    hicu_bin_ram u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hicu_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // degree clamp and bin position
    always_comb
    begin
        if (CMP_W'(item.vertex_degree) > CMP_W'(MAX_DEGREE))
        begin
            deg_in = ADDR_W'(MAX_DEGREE);
        end
        else
        begin
            deg_in = ADDR_W'(item.vertex_degree);
        end
        deg_cmp   = CMP_W'(deg_in);
        ncore_cmp = CMP_W'(item.neighbour_core);
        pos_in    = (ncore_cmp < deg_cmp) ? ADDR_W'(ncore_cmp) : deg_in;
        h_cmp     = CMP_W'(h_reg);
        pres_cmp  = CMP_W'(present_reg);
    end

    always_comb
    begin
        state_next        = state_reg;
        tag_next          = tag_reg;
        deg_next          = deg_reg;
        present_next      = present_reg;
        final_next        = final_reg;
        pos_next          = pos_reg;
        idx_next          = idx_reg;
        sum_next          = sum_reg;
        h_next            = h_reg;
        touched_next      = touched_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        clr_next          = clr_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = alu_res.value[BIN_W-1:0];
        ram_raddr = idx_reg;

        alu_req.op  = OP_INC;
        alu_req.acc = sum_reg;
        alu_req.bin = ram_rdata;
        alu_req.idx = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = pos_in;
                if (accept)
                begin
                    tag_next     = item.vertex_tag;
                    deg_next     = deg_in;
                    present_next = item.present_core;
                    final_next   = item.final_item;
                    pos_next     = pos_in;
                    idx_next     = deg_in;
                    sum_next     = '0;
                    h_next       = '0;
                    if (item.counts)
                    begin
                        touched_next = 1'b1;
                        if (!touched_reg || pos_in > hi_reg)
                        begin
                            hi_next = pos_in;
                        end
                        if (!touched_reg || pos_in < lo_reg)
                        begin
                            lo_next = pos_in;
                        end
                        state_next = ST_INC;
                    end
                    else if (item.final_item)
                    begin
                        state_next = (deg_in == '0) ? ST_EMIT : ST_SCAN_RD;
                    end
                end
            end
            ST_INC:
            begin
                alu_req.op = OP_INC;
                ram_we     = 1'b1;
                if (final_reg)
                begin
                    state_next = (deg_reg == '0) ? ST_EMIT : ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                alu_req.op = OP_ACC;
                sum_next   = alu_res.value;
                ram_raddr  = idx_reg - addr_t'(1);
                if (alu_res.reached)
                begin
                    h_next     = idx_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg - addr_t'(1);
                end
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.result_tag = tag_reg;
                    if (h_cmp < pres_cmp)
                    begin
                        result_next.updated_core = CORE_W'(h_cmp);
                        result_next.lowered      = 1'b1;
                    end
                    else
                    begin
                        result_next.updated_core = present_reg;
                        result_next.lowered      = 1'b0;
                    end
                    result_valid_next = 1'b1;
                    touched_next      = 1'b0;
                    clr_next          = hi_reg;
                    state_next        = touched_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == lo_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg - addr_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            tag_reg          <= '0;
            deg_reg          <= '0;
            present_reg      <= '0;
            final_reg        <= 1'b0;
            pos_reg          <= '0;
            idx_reg          <= '0;
            sum_reg          <= '0;
            h_reg            <= '0;
            touched_reg      <= 1'b0;
            hi_reg           <= '0;
            lo_reg           <= '0;
            clr_reg          <= ADDR_W'(MAX_DEGREE);
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tag_reg          <= tag_next;
            deg_reg          <= deg_next;
            present_reg      <= present_next;
            final_reg        <= final_next;
            pos_reg          <= pos_next;
            idx_reg          <= idx_next;
            sum_reg          <= sum_next;
            h_reg            <= h_next;
            touched_reg      <= touched_next;
            hi_reg           <= hi_next;
            lo_reg           <= lo_next;
            clr_reg          <= clr_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // suffix sum never passes the index while the scan runs
    a_scan_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (sum_reg <= SUM_W'(idx_reg)))
        else $error("scan sum exceeds index");

    a_scan_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= deg_reg))
        else $error("scan index out of range");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_SCAN_RD) |-> !ram_we)
        else $error("bin write during scan");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

endmodule

@@ dv/h_index_core_update_tb.sv @@
`timescale 1ns / 100ps
// h_index_core_update_tb: self-checking bench for the h-index core update block.
// Queue-fed driver, clocked monitor and an in-bench histogram predictor.
// Depends on hicu_pkg and h_index_core_update.
module h_index_core_update_tb;

    import hicu_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2400;
    localparam int RANDOM_ITEMS = 720;
    localparam int SAT_ITEMS    = 1030;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic    item_fire    = 1'b0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      cycle_count   = 0;
    int      mismatch_count = 0;
    int      items_accepted = 0;
    int      results_checked = 0;
    int      lowered_seen   = 0;
    int      vertices_queued = 0;

    item_t   pending_items[$];
    result_t core_expected[$];
    result_t want;

    logic [BIN_W-1:0] neighbour_hist [0:DEPTH-1];

    h_index_core_update u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // bin a counted neighbour; on the last item scan for the h-index and clear the histogram
    task automatic predict_core(input item_t it);
        int unsigned deg;
        int unsigned pos;
        int unsigned run_sum;
        int unsigned h;
        int          i;
        result_t     r;
        deg = it.vertex_degree;
        if (deg > MAX_DEGREE)
            deg = MAX_DEGREE;
        if (it.counts)
        begin
            pos = (it.neighbour_core < deg) ? it.neighbour_core : deg;
            if (neighbour_hist[pos] != BIN_MAX)
                neighbour_hist[pos] = neighbour_hist[pos] + 1'b1;
        end
        if (it.final_item)
        begin
            h = 0;
            run_sum = 0;
            if (deg != 0)
            begin
                for (i = deg; i >= 0; i--)
                begin
                    run_sum += neighbour_hist[i];
                    if (run_sum >= i)
                    begin
                        h = i;
                        break;
                    end
                end
            end
            r.result_tag = it.vertex_tag;
            if (h < it.present_core)
            begin
                r.updated_core = CORE_W'(h);
                r.lowered      = 1'b1;
            end
            else
            begin
                r.updated_core = it.present_core;
                r.lowered      = 1'b0;
            end
            core_expected = {core_expected, r};
            foreach (neighbour_hist[j])
                neighbour_hist[j] = '0;
        end
    endtask

    task automatic push_item(input int unsigned tag, input int unsigned ncore,
                             input int unsigned deg, input int unsigned pres,
                             input bit cnt, input bit fin);
        item_t it;
        it.vertex_tag     = TAG_W'(tag);
        it.neighbour_core = CORE_W'(ncore);
        it.vertex_degree  = CORE_W'(deg);
        it.present_core   = CORE_W'(pres);
        it.counts         = cnt;
        it.final_item     = fin;
        pending_items = {pending_items, it};
    endtask

    // one vertex run; drift gives each item its own degree
    task automatic queue_vertex(input int unsigned n, input int unsigned deg,
                                input int unsigned pres, input bit drift);
        int unsigned tag;
        int unsigned k;
        int unsigned ncore;
        int unsigned top;
        int unsigned d;
        tag = $urandom_range(0, 65535);
        top = (deg + 4 > 1023) ? 1023 : deg + 4;
        for (k = 0; k < n; k++)
        begin
            d = drift ? $urandom_range(0, 40) : deg;
            if (drift && k == n - 1)
                d = deg;
            ncore = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, top);
            push_item(tag, ncore, d, pres, $urandom_range(0, 9) != 0, k == n - 1);
        end
        vertices_queued++;
    endtask

    task automatic queue_random_vertices(input int budget);
        int          added;
        int unsigned deg;
        int unsigned n;
        int unsigned pres;
        int unsigned roll;
        added = 0;
        while (added < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                deg = $urandom_range(0, 16);
            else if (roll < 92)
                deg = $urandom_range(17, 100);
            else
                deg = $urandom_range(101, 1023);
            if ($urandom_range(0, 3) == 0)
                n = (deg + 2 > 40) ? 40 : deg + 2;
            else
                n = $urandom_range(1, 12);
            pres = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, deg + 2);
            queue_vertex(n, deg, pres, $urandom_range(0, 9) == 0);
            added += n;
        end
    endtask

    task automatic wait_items_drained;
        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
    endtask

    // driver: inputs move on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            result_stall <= 1'b0;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (!item_valid || item_fire)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: sample both channels on the rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n)
        begin
            item_fire <= 1'b0;
        end
        else
        begin
            item_fire <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                items_accepted <= items_accepted + 1;
                predict_core(item);
            end
            if (result_valid && !result_stall)
            begin
                results_checked <= results_checked + 1;
                if (result.lowered === 1'b1)
                    lowered_seen <= lowered_seen + 1;
                if (core_expected.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result: tag %h core %0d lowered %0d",
                                 result.result_tag, result.updated_core, result.lowered);
                end
                else
                begin
                    want = core_expected.pop_front();
                    if (result.result_tag !== want.result_tag ||
                        result.updated_core !== want.updated_core ||
                        result.lowered !== want.lowered)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("bad result: tag %h/%h core %0d/%0d lowered %0d/%0d (exp/got)",
                                     want.result_tag, result.result_tag,
                                     want.updated_core, result.updated_core,
                                     want.lowered, result.lowered);
                    end
                end
            end
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        foreach (neighbour_hist[j])
            neighbour_hist[j] = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // sender idles less than the receiver
        send_idle_pct = 32;
        recv_idle_pct = 61;

        // empty vertices, with and without a higher present core
        push_item(16'h0000, 5, 0, 0, 1'b1, 1'b1);
        push_item(16'hFFFF, 1023, 0, 7, 1'b1, 1'b1);
        // final item that counts nothing
        push_item(16'h1234, 2, 3, 3, 1'b0, 1'b1);
        // widest degree, every neighbour core equal to it
        push_item(16'hFFFF, 1023, 1023, 1023, 1'b1, 1'b0);
        push_item(16'hFFFF, 1023, 1023, 1023, 1'b1, 1'b0);
        push_item(16'hFFFF, 1023, 1023, 1023, 1'b1, 1'b1);
        // h-index equals present core, so no lowering
        push_item(16'h00A5, 1023, 3, 2, 1'b1, 1'b0);
        push_item(16'h00A5, 1023, 3, 2, 1'b1, 1'b0);
        push_item(16'h00A5, 0, 3, 2, 1'b1, 1'b1);
        // degree changes within the run
        push_item(16'h5A5A, 8, 10, 9, 1'b1, 1'b0);
        push_item(16'h5A5A, 8, 2, 9, 1'b1, 1'b0);
        push_item(16'h5A5A, 5, 5, 9, 1'b1, 1'b1);
        // full house: h equals degree
        repeat (4) push_item(16'h8001, 5, 5, 1023, 1'b1, 1'b0);
        push_item(16'h8001, 5, 5, 1023, 1'b1, 1'b1);
        // an uncounted item mid-run, present core zero
        push_item(16'h7FFE, 600, 4, 0, 1'b0, 1'b0);
        push_item(16'h7FFE, 4, 4, 0, 1'b1, 1'b0);
        push_item(16'h7FFE, 512, 4, 0, 1'b1, 1'b1);
        vertices_queued += 8;

        queue_random_vertices(RANDOM_ITEMS / 3);
        wait_items_drained();

        send_idle_pct = 61;
        recv_idle_pct = 32;
        queue_random_vertices(RANDOM_ITEMS / 3);
        wait_items_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // one bin pushed past its count limit; a wrapping count would end at 6
        begin
            int unsigned sat_bin;
            int unsigned k;
            sat_bin = $urandom_range(300, 900);
            for (k = 0; k < SAT_ITEMS; k++)
                push_item(16'hC0DE, sat_bin, 1023, 1023, 1'b1, k == SAT_ITEMS - 1);
            vertices_queued++;
        end
        queue_random_vertices(RANDOM_ITEMS / 3);
        wait_items_drained();

        while (core_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items over %0d vertices; %0d results compared, %0d with a lowered core",
                 items_accepted, vertices_queued, results_checked, lowered_seen);
        $display("idle mixes: sender-light, receiver-light and none; one saturated bin run");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
